>>> sv/lob_pkg.sv
// Shared types and constants for the top-of-book limit order book.
package lob_pkg;

    localparam int unsigned PriceW = 16;
    localparam int unsigned IdW = 32;
    localparam int unsigned SizeW = 8;
    localparam int unsigned SlotW = PriceW + IdW + SizeW;

    typedef logic [2:0] t_func;
    localparam t_func FuncAddBid = 3'd0;
    localparam t_func FuncCanBid = 3'd1;
    localparam t_func FuncAddAsk = 3'd2;
    localparam t_func FuncCanAsk = 3'd3;

    typedef struct packed {
        logic signed [PriceW-1:0] price;
        logic [IdW-1:0] id;
        logic [SizeW-1:0] size;
    } t_slot;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS_RD,
        S_INS_WAIT,
        S_INS_STEP,
        S_POP_TOP,
        S_POP_WAIT,
        S_POP_STEP,
        S_POP_CWAIT,
        S_POP_CSTEP,
        S_POP_FIN,
        S_NEXT,
        S_TOPS_RD,
        S_TOPS_WAIT,
        S_TOPS_CHK,
        S_EMIT
    } t_state;

    // Returns true when a beats b in heap k (bit 0 set: ask ordering).
    function automatic logic beats(input logic ask, input t_slot a, input t_slot b);
        logic r;
        if (a.id == '0) begin
            r = 1'b0;
        end else if (b.id == '0) begin
            r = 1'b1;
        end else if (a.price == b.price) begin
            r = a.id < b.id;
        end else if (ask) begin
            r = a.price < b.price;
        end else begin
            r = a.price > b.price;
        end
        return r;
    endfunction

endpackage

>>> sv/limit_order_book_top_of_book.sv
// Top level of the top-of-book limit order book with four heaps in one memory.
// A query passes through the dispatch and emit states before its result is registered.
// An insert walks the heap level by level and a pop walks down from the top
// through one shared synchronous memory port, and an id-0 cancel may pop several tops.
// After reset a clearing pass writes every slot of the heap memory empty;
// busy stays high during it. Results appear for one cycle on o_valid; the receiver cannot stall.
module limit_order_book_top_of_book #(
    parameter int unsigned HEAP_LEVELS = 12,
    parameter int unsigned HEAP_CAPACITY = 4096,
    parameter int unsigned TIME_BITS = 64,
    parameter int unsigned META_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [2:0]           i_func,
    input  logic [31:0]          i_order_id,
    input  logic signed [15:0]   i_price,
    input  logic [7:0]           i_quantity,
    input  logic [63:0]          i_time_stamp,
    input  logic [31:0]          i_meta_tag,
    output logic                 o_valid,
    output logic signed [15:0]   o_best_bid_price,
    output logic [31:0]          o_best_bid_id,
    output logic [7:0]           o_best_bid_size,
    output logic signed [15:0]   o_best_ask_price,
    output logic [31:0]          o_best_ask_id,
    output logic [7:0]           o_best_ask_size,
    output logic [63:0]          o_time_stamp_out,
    output logic [31:0]          o_meta_tag_out
);
    localparam int unsigned L = HEAP_LEVELS;
    localparam int unsigned NSLOT = 1 << L;
    localparam int unsigned AW = L + 2;
    localparam int unsigned FILL = ((NSLOT - 1) < (HEAP_CAPACITY - 1)) ?
                                   (NSLOT - 1) : (HEAP_CAPACITY - 1);
    localparam int unsigned CW = $clog2(HEAP_CAPACITY + 1);
    localparam int unsigned HW = (HEAP_CAPACITY > 1) ? $clog2(HEAP_CAPACITY) : 1;
    localparam int unsigned DW = $clog2(L + 1);
    localparam int unsigned PW = (L > 1) ? L - 1 : 1;

    // Heap memory: four heaps, each with 2^L slots.
    lob_pkg::t_slot r_mem [4 * NSLOT];
    logic [PW-1:0] r_hole [4 * HEAP_CAPACITY];

    logic          mem_we;
    logic [AW-1:0] mem_addr;
    lob_pkg::t_slot mem_wd, r_rd;
    logic          hole_we;
    logic [HW+1:0] hole_waddr, hole_raddr;
    logic [PW-1:0] hole_wd, r_hole_rd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wd;
        end
        r_rd <= r_mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (hole_we) begin
            r_hole[hole_waddr] <= hole_wd;
        end
        r_hole_rd <= r_hole[hole_raddr];
    end

    lob_pkg::t_state r_state, n_state;
    logic [AW:0]   r_clr, n_clr;
    logic          r_clr_done, n_clr_done;
    logic [CW-1:0] r_cnt [4];
    logic [CW-1:0] r_hc [4];
    logic [CW-1:0] n_cnt [4];
    logic [CW-1:0] n_hc [4];
    logic [2:0]    r_func, n_func;
    lob_pkg::t_slot r_req, n_req;
    logic [8:0]    r_left, n_left;
    logic [1:0]    r_k, n_k;
    lob_pkg::t_slot r_item, n_item;
    logic [L:0]    r_node, n_node;
    logic [L:0]    r_tgt, n_tgt;
    logic [DW-1:0] r_d, n_d;
    lob_pkg::t_slot r_left_c, n_left_c;
    lob_pkg::t_slot r_bt, n_bt, r_at, n_at, r_ct, n_ct;
    logic [1:0]    r_ph, n_ph;
    // Sequence after a pop: 0 none, 1 pop cancel heap, 2 purge check.
    logic [1:0]    r_after, n_after;
    logic [63:0]   r_ts;
    logic [31:0]   r_meta;
    logic          r_ov, n_ov;
    lob_pkg::t_slot r_ob, r_oa;

    function automatic logic [DW-1:0] lvl(input logic [L:0] n);
        logic [DW-1:0] d;
        d = '0;
        for (int i = 1; i <= L; i++) begin
            if (n[i]) d = DW'(i);
        end
        return d;
    endfunction

    function automatic logic [AW-1:0] adr(input logic [1:0] k, input logic [L:0] n);
        return {k, n[L-1:0]};
    endfunction

    logic side;
    logic [L:0] tnode;
    logic [L:0] lch;
    logic [L:0] bottom;
    lob_pkg::t_slot top_sel;

    always_comb begin
        n_state = r_state;
        n_clr = r_clr;
        n_clr_done = r_clr_done;
        n_cnt = r_cnt;
        n_hc = r_hc;
        n_func = r_func;
        n_req = r_req;
        n_left = r_left;
        n_k = r_k;
        n_item = r_item;
        n_node = r_node;
        n_tgt = r_tgt;
        n_d = r_d;
        n_left_c = r_left_c;
        n_bt = r_bt;
        n_at = r_at;
        n_ct = r_ct;
        n_ph = r_ph;
        n_after = r_after;
        n_ov = 1'b0;
        mem_we = 1'b0;
        mem_addr = '0;
        mem_wd = '0;
        hole_we = 1'b0;
        hole_waddr = '0;
        hole_raddr = '0;
        hole_wd = '0;
        side = r_func[1];
        tnode = (r_tgt >> r_d) & (L+1)'(NSLOT - 1);
        lch = {r_node[L-1:0], 1'b0};
        bottom = r_node;
        for (int i = 0; i < L; i++) begin
            if (bottom < (L+1)'(NSLOT / 2)) bottom = {bottom[L-1:0], 1'b0};
        end
        top_sel = side ? r_at : r_bt;
        unique case (r_state)
            lob_pkg::S_IDLE: begin
                if (!r_clr_done) begin
                    mem_we = 1'b1;
                    mem_addr = r_clr[AW-1:0];
                    n_clr = r_clr + 1'b1;
                    if (r_clr[AW-1:0] == '1) n_clr_done = 1'b1;
                end else if (start) begin
                    n_func = i_func;
                    n_req = '{price: i_price, id: i_order_id, size: i_quantity};
                    n_left = {1'b0, i_quantity};
                    n_state = lob_pkg::S_DISPATCH;
                end
            end
            lob_pkg::S_DISPATCH: begin
                n_after = 2'd0;
                if ((r_func == lob_pkg::FuncAddBid || r_func == lob_pkg::FuncAddAsk)
                    && r_req.id != '0) begin
                    n_k = {1'b0, side};
                    n_item = r_req;
                    n_state = lob_pkg::S_INS_RD;
                end else if (r_func == lob_pkg::FuncCanBid
                             || r_func == lob_pkg::FuncCanAsk) begin
                    if (r_req.id == '0) begin
                        n_state = lob_pkg::S_NEXT;
                    end else if (r_req.id == top_sel.id) begin
                        n_k = {1'b0, side};
                        n_after = 2'd2;
                        n_state = lob_pkg::S_POP_TOP;
                    end else begin
                        n_k = {1'b1, side};
                        n_item = r_req;
                        n_state = lob_pkg::S_INS_RD;
                    end
                end else begin
                    n_state = lob_pkg::S_EMIT;
                end
            end
            lob_pkg::S_INS_RD: begin
                hole_raddr = {r_k, HW'(r_hc[r_k] - 1'b1)};
                n_state = lob_pkg::S_INS_WAIT;
            end
            lob_pkg::S_INS_WAIT: begin
                if (r_hc[r_k] != '0) begin
                    n_hc[r_k] = r_hc[r_k] - 1'b1;
                    n_tgt = (L+1)'(NSLOT / 2) | (L+1)'(r_hole_rd);
                    if (r_cnt[r_k] < CW'(FILL)) n_cnt[r_k] = r_cnt[r_k] + 1'b1;
                    n_d = DW'(L - 1);
                end else if (r_cnt[r_k] < CW'(FILL)) begin
                    n_cnt[r_k] = r_cnt[r_k] + 1'b1;
                    n_tgt = (L+1)'(r_cnt[r_k] + 1'b1);
                    n_d = lvl((L+1)'(r_cnt[r_k] + 1'b1));
                end else begin
                    n_tgt = (L+1)'(FILL);
                    n_d = lvl((L+1)'(FILL));
                end
                n_ph = 2'd0;
                n_state = lob_pkg::S_INS_STEP;
            end
            lob_pkg::S_INS_STEP: begin
                mem_addr = adr(r_k, tnode);
                if (r_ph == 2'd0) begin
                    n_ph = 2'd1;
                end else if (r_ph == 2'd1) begin
                    n_ph = 2'd2;
                end else begin
                    n_ph = 2'd1;
                    if (r_rd.id == '0) begin
                        mem_we = 1'b1;
                        mem_wd = r_item;
                        n_state = lob_pkg::S_TOPS_RD;
                    end else begin
                        if (lob_pkg::beats(r_k[0], r_item, r_rd)) begin
                            mem_we = 1'b1;
                            mem_wd = r_item;
                            n_item = r_rd;
                        end
                        if (r_d == '0) begin
                            n_state = lob_pkg::S_TOPS_RD;
                        end else begin
                            n_d = r_d - 1'b1;
                            n_ph = 2'd0;
                        end
                    end
                end
            end
            lob_pkg::S_POP_TOP: begin
                n_node = (L+1)'(1);
                n_state = lob_pkg::S_POP_STEP;
                n_ph = 2'd0;
            end
            lob_pkg::S_POP_STEP: begin
                if (r_node >= (L+1)'(NSLOT / 2)) begin
                    n_state = lob_pkg::S_POP_FIN;
                end else begin
                    mem_addr = adr(r_k, lch);
                    n_state = lob_pkg::S_POP_WAIT;
                end
            end
            lob_pkg::S_POP_WAIT: begin
                mem_addr = adr(r_k, lch | (L+1)'(1));
                n_left_c = r_rd;
                n_state = lob_pkg::S_POP_CWAIT;
            end
            lob_pkg::S_POP_CWAIT: begin
                mem_addr = adr(r_k, lch | (L+1)'(1));
                n_state = lob_pkg::S_POP_CSTEP;
            end
            lob_pkg::S_POP_CSTEP: begin
                if (lob_pkg::beats(r_k[0], r_rd, r_left_c)) begin
                    if (r_rd.id == '0) begin
                        n_state = lob_pkg::S_POP_FIN;
                    end else begin
                        mem_we = 1'b1;
                        mem_addr = adr(r_k, r_node);
                        mem_wd = r_rd;
                        n_node = lch | (L+1)'(1);
                        n_state = lob_pkg::S_POP_STEP;
                    end
                end else if (r_left_c.id == '0) begin
                    n_state = lob_pkg::S_POP_FIN;
                end else begin
                    mem_we = 1'b1;
                    mem_addr = adr(r_k, r_node);
                    mem_wd = r_left_c;
                    n_node = lch;
                    n_state = lob_pkg::S_POP_STEP;
                end
            end
            lob_pkg::S_POP_FIN: begin
                mem_we = 1'b1;
                mem_addr = adr(r_k, r_node);
                mem_wd = '0;
                if (r_hc[r_k] < CW'(HEAP_CAPACITY)) begin
                    hole_we = 1'b1;
                    hole_waddr = {r_k, HW'(r_hc[r_k])};
                    hole_wd = PW'(bottom);
                    n_hc[r_k] = r_hc[r_k] + 1'b1;
                end
                if (r_cnt[r_k] != '0) n_cnt[r_k] = r_cnt[r_k] - 1'b1;
                if (r_after == 2'd1) begin
                    n_k = {1'b1, side};
                    n_after = 2'd2;
                    n_state = lob_pkg::S_POP_TOP;
                end else begin
                    n_state = lob_pkg::S_TOPS_RD;
                end
            end
            lob_pkg::S_TOPS_RD: begin
                mem_addr = adr({1'b0, side}, (L+1)'(1));
                n_ph = 2'd0;
                n_state = lob_pkg::S_TOPS_WAIT;
            end
            lob_pkg::S_TOPS_WAIT: begin
                if (r_ph == 2'd0) begin
                    mem_addr = adr({1'b1, side}, (L+1)'(1));
                    if (side) n_at = r_rd; else n_bt = r_rd;
                    n_ph = 2'd1;
                end else begin
                    n_ct = r_rd;
                    n_state = lob_pkg::S_TOPS_CHK;
                end
            end
            lob_pkg::S_TOPS_CHK: begin
                if (top_sel.id != '0 && r_ct.id == top_sel.id
                    && (r_func == lob_pkg::FuncCanBid || r_func == lob_pkg::FuncCanAsk)
                    && (r_req.id == '0 || r_after != 2'd0)) begin
                    n_k = {1'b0, side};
                    n_after = 2'd1;
                    n_state = lob_pkg::S_POP_TOP;
                end else if ((r_func == lob_pkg::FuncCanBid || r_func == lob_pkg::FuncCanAsk)
                             && r_req.id == '0) begin
                    n_state = lob_pkg::S_NEXT;
                end else begin
                    n_state = lob_pkg::S_EMIT;
                end
            end
            lob_pkg::S_NEXT: begin
                if (r_left == '0 || top_sel.id == '0) begin
                    n_state = lob_pkg::S_EMIT;
                end else if (r_left < {1'b0, top_sel.size}) begin
                    mem_we = 1'b1;
                    mem_addr = adr({1'b0, side}, (L+1)'(1));
                    mem_wd = top_sel;
                    mem_wd.size = top_sel.size - r_left[7:0];
                    n_left = '0;
                    n_state = lob_pkg::S_TOPS_RD;
                end else begin
                    n_left = r_left - {1'b0, top_sel.size};
                    n_k = {1'b0, side};
                    n_after = 2'd0;
                    n_state = lob_pkg::S_POP_TOP;
                end
            end
            lob_pkg::S_EMIT: begin
                n_ov = 1'b1;
                n_state = lob_pkg::S_IDLE;
            end
            default: n_state = lob_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lob_pkg::S_IDLE;
            r_clr <= '0;
            r_clr_done <= 1'b0;
            r_ov <= 1'b0;
            r_bt <= '0;
            r_at <= '0;
            for (int i = 0; i < 4; i++) begin
                r_cnt[i] <= '0;
                r_hc[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_clr <= n_clr;
            r_clr_done <= n_clr_done;
            r_ov <= n_ov;
            r_bt <= n_bt;
            r_at <= n_at;
            r_cnt <= n_cnt;
            r_hc <= n_hc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func <= n_func;
        r_req <= n_req;
        r_left <= n_left;
        r_k <= n_k;
        r_item <= n_item;
        r_node <= n_node;
        r_tgt <= n_tgt;
        r_d <= n_d;
        r_left_c <= n_left_c;
        r_ct <= n_ct;
        r_ph <= n_ph;
        r_after <= n_after;
        if (r_state == lob_pkg::S_IDLE && r_clr_done && start) begin
            r_ts <= 64'(i_time_stamp[TIME_BITS-1:0]);
            r_meta <= 32'(i_meta_tag[((META_BITS < 32) ? META_BITS : 32)-1:0]);
        end
        if (n_ov) begin
            r_ob <= r_bt;
            r_oa <= r_at;
        end
    end

    assign busy = (r_state != lob_pkg::S_IDLE) || !r_clr_done;
    assign o_valid = r_ov;
    assign o_best_bid_price = r_ob.price;
    assign o_best_bid_id = r_ob.id;
    assign o_best_bid_size = r_ob.size;
    assign o_best_ask_price = r_oa.price;
    assign o_best_ask_id = r_oa.id;
    assign o_best_ask_size = r_oa.size;
    assign o_time_stamp_out = r_ts;
    assign o_meta_tag_out = r_meta;

    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_clr_done |-> busy) else $error("busy low during clearing pass");
    a_emit_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe held");
    a_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_state == lob_pkg::S_IDLE) else $error("strobe outside idle");
endmodule

>>> test/tb_top.sv
// Self-checking testbench for the top-of-book limit order book with its own book predictor.
`timescale 1ns / 100ps

module tb_top;

    localparam int unsigned Levels = 12;
    localparam int unsigned Slots = 1 << Levels;
    localparam int unsigned BottomFirst = 1 << (Levels - 1);
    localparam int unsigned FillLimit = Slots - 1;
    localparam int unsigned CycleLimit = 1000000;
    localparam int unsigned RandomItems = 450;
    localparam lob_pkg::t_func FuncQuery = 3'd4;

    typedef struct {
        lob_pkg::t_func func;
        logic [31:0] id;
        logic signed [15:0] price;
        logic [7:0] qty;
        logic [63:0] ts;
        logic [31:0] meta;
    } t_order;

    typedef struct {
        lob_pkg::t_slot bid;
        lob_pkg::t_slot ask;
        logic [63:0] ts;
        logic [31:0] meta;
    } t_top_view;

    typedef struct {
        t_order ord;
        bit typed;
        t_top_view view;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [2:0] i_func = '0;
    logic [31:0] i_order_id = '0;
    logic signed [15:0] i_price = '0;
    logic [7:0] i_quantity = '0;
    logic [63:0] i_time_stamp = '0;
    logic [31:0] i_meta_tag = '0;
    logic o_valid;
    logic signed [15:0] o_best_bid_price;
    logic [31:0] o_best_bid_id;
    logic [7:0] o_best_bid_size;
    logic signed [15:0] o_best_ask_price;
    logic [31:0] o_best_ask_id;
    logic [7:0] o_best_ask_size;
    logic [63:0] o_time_stamp_out;
    logic [31:0] o_meta_tag_out;

    lob_pkg::t_slot book [4][Slots];
    int unsigned live_count [4];
    int unsigned hole_count [4];
    int unsigned hole_path [4][Slots];
    t_top_view pending_tops [$];
    int unsigned errors = 0;
    int unsigned cycles = 0;

    limit_order_book_top_of_book dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_func(i_func), .i_order_id(i_order_id), .i_price(i_price),
        .i_quantity(i_quantity), .i_time_stamp(i_time_stamp), .i_meta_tag(i_meta_tag),
        .o_valid(o_valid), .o_best_bid_price(o_best_bid_price),
        .o_best_bid_id(o_best_bid_id), .o_best_bid_size(o_best_bid_size),
        .o_best_ask_price(o_best_ask_price), .o_best_ask_id(o_best_ask_id),
        .o_best_ask_size(o_best_ask_size), .o_time_stamp_out(o_time_stamp_out),
        .o_meta_tag_out(o_meta_tag_out)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic bit outranks(int k, lob_pkg::t_slot a, lob_pkg::t_slot b);
        bit r;
        if (a.id == 0) r = 0;
        else if (b.id == 0) r = 1;
        else if (a.price == b.price) r = a.id < b.id;
        else if (k[0]) r = a.price < b.price;
        else r = a.price > b.price;
        return r;
    endfunction

    function automatic void book_insert(int k, lob_pkg::t_slot item);
        int unsigned target;
        int unsigned n;
        int d;
        lob_pkg::t_slot t;
        if (hole_count[k] > 0) begin
            hole_count[k]--;
            target = BottomFirst + (hole_path[k][hole_count[k]] & (BottomFirst - 1));
            if (live_count[k] < FillLimit) live_count[k]++;
        end else if (live_count[k] < FillLimit) begin
            live_count[k]++;
            target = live_count[k];
        end else begin
            target = FillLimit;
        end
        d = $clog2(target + 1) - 1;
        for (; d >= 0; d--) begin
            n = (target >> d) & (Slots - 1);
            if (book[k][n].id == 0) begin
                book[k][n] = item;
                return;
            end
            if (outranks(k, item, book[k][n])) begin
                t = book[k][n];
                book[k][n] = item;
                item = t;
            end
        end
    endfunction

    function automatic void book_pop(int k);
        int unsigned n;
        int unsigned pick;
        int unsigned b;
        n = 1;
        if (book[k][1].id == 0) return;
        while (n < BottomFirst) begin
            pick = outranks(k, book[k][2*n+1], book[k][2*n]) ? 2*n+1 : 2*n;
            if (book[k][pick].id == 0) break;
            book[k][n] = book[k][pick];
            n = pick;
        end
        book[k][n] = '0;
        b = n;
        while (b < BottomFirst) b = b << 1;
        if (hole_count[k] < Slots) begin
            hole_path[k][hole_count[k]] = b - BottomFirst;
            hole_count[k]++;
        end
        if (live_count[k] > 0) live_count[k]--;
    endfunction

    function automatic void drop_cancelled(int side);
        while (book[side][1].id != 0 && book[side+2][1].id == book[side][1].id) begin
            book_pop(side);
            book_pop(side + 2);
        end
    endfunction

    function automatic void book_cancel(int side, lob_pkg::t_slot req);
        int unsigned left;
        if (req.id == 0) begin
            left = req.size;
            while (left > 0 && book[side][1].id != 0) begin
                if (left < book[side][1].size) begin
                    book[side][1].size = book[side][1].size - left;
                    left = 0;
                end else begin
                    left = left - book[side][1].size;
                    book_pop(side);
                end
                drop_cancelled(side);
            end
        end else if (req.id == book[side][1].id) begin
            book_pop(side);
            drop_cancelled(side);
        end else begin
            book_insert(side + 2, req);
        end
    endfunction

    function automatic t_top_view apply_order(t_order o);
        lob_pkg::t_slot s;
        t_top_view v;
        s.price = o.price;
        s.id = o.id;
        s.size = o.qty;
        case (o.func)
            lob_pkg::FuncAddBid: if (o.id != 0) book_insert(0, s);
            lob_pkg::FuncCanBid: book_cancel(0, s);
            lob_pkg::FuncAddAsk: if (o.id != 0) book_insert(1, s);
            lob_pkg::FuncCanAsk: book_cancel(1, s);
            default: ;
        endcase
        v.bid = book[0][1];
        v.ask = book[1][1];
        v.ts = o.ts;
        v.meta = o.meta;
        return v;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", field, got, want, $realtime);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_top_view w;
        cycles <= cycles + 1;
        if (i_rst_n && o_valid) begin
            if (pending_tops.size() == 0) begin
                report_mismatch("unexpected transaction", 0, 0);
            end else begin
                w = pending_tops.pop_front();
                if (o_best_bid_price !== w.bid.price) report_mismatch("bid price", o_best_bid_price, w.bid.price);
                if (o_best_bid_id !== w.bid.id) report_mismatch("bid id", o_best_bid_id, w.bid.id);
                if (o_best_bid_size !== w.bid.size) report_mismatch("bid size", o_best_bid_size, w.bid.size);
                if (o_best_ask_price !== w.ask.price) report_mismatch("ask price", o_best_ask_price, w.ask.price);
                if (o_best_ask_id !== w.ask.id) report_mismatch("ask id", o_best_ask_id, w.ask.id);
                if (o_best_ask_size !== w.ask.size) report_mismatch("ask size", o_best_ask_size, w.ask.size);
                if (o_time_stamp_out !== w.ts) report_mismatch("time stamp", o_time_stamp_out, w.ts);
                if (o_meta_tag_out !== w.meta) report_mismatch("meta tag", o_meta_tag_out, w.meta);
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles >= CycleLimit) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_order(t_order o, bit typed, t_top_view typed_view, int unsigned idle_pct);
        t_top_view v;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_func <= o.func;
        i_order_id <= o.id;
        i_price <= o.price;
        i_quantity <= o.qty;
        i_time_stamp <= o.ts;
        i_meta_tag <= o.meta;
        do @(posedge i_clk); while (busy);
        v = apply_order(o);
        pending_tops.push_back(typed ? typed_view : v);
    endtask

    function automatic t_order make_order(lob_pkg::t_func f, logic [31:0] id,
                                          logic signed [15:0] p, logic [7:0] q);
        t_order o;
        o.func = f;
        o.id = id;
        o.price = p;
        o.qty = q;
        o.ts = {$urandom, $urandom};
        o.meta = $urandom;
        return o;
    endfunction

    function automatic t_order random_order();
        t_order o;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 30) o.func = lob_pkg::FuncAddBid;
        else if (pick < 60) o.func = lob_pkg::FuncAddAsk;
        else if (pick < 75) o.func = lob_pkg::FuncCanBid;
        else if (pick < 90) o.func = lob_pkg::FuncCanAsk;
        else o.func = lob_pkg::t_func'($urandom_range(7, 4));
        pick = $urandom_range(99);
        if (pick < 12) o.id = 0;
        else if (pick < 90) o.id = $urandom_range(60, 1);
        else o.id = $urandom;
        if ($urandom_range(9) < 8) o.price = $signed(16'($urandom_range(40))) - 16'sd20;
        else o.price = 16'($urandom);
        o.qty = ($urandom_range(9) < 8) ? 8'($urandom_range(30)) : 8'($urandom);
        o.ts = {$urandom, $urandom};
        o.meta = $urandom;
        return o;
    endfunction

    initial begin
        t_row rows [$];
        t_row r;
        t_top_view blank;
        int unsigned pct;
        int unsigned wait_cycles;
        blank = '{bid: '0, ask: '0, ts: '0, meta: '0};
        for (int k = 0; k < 4; k++) begin
            live_count[k] = 0;
            hole_count[k] = 0;
            for (int n = 0; n < Slots; n++) book[k][n] = '0;
        end

        r.typed = 1;
        r.ord = make_order(FuncQuery, 32'hFFFF_FFFF, 16'sh7FFF, 8'hFF);
        r.ord.ts = '1;
        r.ord.meta = '1;
        r.view = blank;
        r.view.ts = '1;
        r.view.meta = '1;
        rows.push_back(r);
        r.typed = 0;
        r.ord = make_order(lob_pkg::FuncAddBid, 5, 16'sh7FFF, 8'hFF); rows.push_back(r);
        r.ord = make_order(lob_pkg::FuncAddBid, 0, 16'sh0100, 8'h10); rows.push_back(r);
        r.ord = make_order(lob_pkg::FuncAddAsk, 7, -16'sd32768, 8'h01); rows.push_back(r);
        r.ord = make_order(lob_pkg::FuncAddAsk, 3, -16'sd32768, 8'h02); rows.push_back(r);
        r.ord = make_order(lob_pkg::FuncCanAsk, 3, 16'sh0000, 8'h00); rows.push_back(r);
        r.ord = make_order(lob_pkg::FuncCanBid, 9, 16'sh0064, 8'h04); rows.push_back(r);
        r.ord = make_order(lob_pkg::FuncAddBid, 9, 16'sh0064, 8'h04); rows.push_back(r);
        r.ord = make_order(lob_pkg::FuncCanBid, 0, 16'sh0000, 8'h00); rows.push_back(r);
        r.ord = make_order(lob_pkg::FuncAddBid, 10, 16'sh0064, 8'h00); rows.push_back(r);
        r.ord = make_order(lob_pkg::FuncAddBid, 32'hFFFF_FFFF, -16'sd32768, 8'h00);
        rows.push_back(r);
        r.ord = make_order(lob_pkg::FuncCanBid, 0, 16'sh0000, 8'h0A); rows.push_back(r);
        r.ord = make_order(lob_pkg::FuncCanBid, 0, 16'sh0000, 8'hFF); rows.push_back(r);
        r.ord = make_order(lob_pkg::FuncCanBid, 0, 16'sh0000, 8'hFF); rows.push_back(r);
        r.ord = make_order(lob_pkg::FuncCanBid, 0, 16'sh0000, 8'h01); rows.push_back(r);
        r.ord = make_order(lob_pkg::FuncCanAsk, 0, 16'sh0000, 8'hFF); rows.push_back(r);
        r.ord = make_order(lob_pkg::FuncCanAsk, 5, 16'sh0000, 8'h01); rows.push_back(r);
        r.ord = make_order(lob_pkg::FuncAddAsk, 5, 16'sh7FFF, 8'h80); rows.push_back(r);
        r.ord = make_order(lob_pkg::FuncCanAsk, 0, 16'sh0000, 8'h40); rows.push_back(r);
        r.ord = make_order(lob_pkg::t_func'(3'd5), 1, 16'sh0001, 8'h01); rows.push_back(r);
        r.ord = make_order(lob_pkg::t_func'(3'd6), 2, 16'sh0002, 8'h02); rows.push_back(r);
        r.ord = make_order(lob_pkg::t_func'(3'd7), 3, 16'sh0003, 8'h03); rows.push_back(r);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i]) send_order(rows[i].ord, rows[i].typed, rows[i].view, 0);
        for (int i = 0; i < RandomItems; i++) begin
            pct = (i < 150) ? 15 : (i < 300) ? 72 : 0;
            send_order(random_order(), 0, blank, pct);
        end
        start <= 1'b0;

        wait_cycles = 0;
        while (pending_tops.size() != 0 && wait_cycles < 200000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (50) @(posedge i_clk);
        if (errors == 0 && pending_tops.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/lob_pkg.sv
sv/limit_order_book_top_of_book.sv
test/tb_top.sv
